[hdl/rational_arithmetic_unit_defines.svh]
// Assertion macros shared by the checker of the rational arithmetic unit.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Condition a implies condition c in the same cycle.
`define RAU_ASSERT_SAME(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("rational unit check failed");

// Condition a implies condition c in the following cycle.
`define RAU_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("rational unit check failed");

`endif

[hdl/rau_pkg.sv]
package rau_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_DIV_ZERO = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_FSET,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_STORE,
		S_OPSEL,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_COMB,
		S_FIN,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		TGT_A,
		TGT_B,
		TGT_R
	} target_t;

	typedef enum logic [1:0] {
		MUL_P1,
		MUL_P2,
		MUL_DEN
	} mul_sel_t;

	typedef struct packed {
		logic       load;
		logic       fset;
		logic       gcd_step;
		logic       div_start;
		logic       div_den;
		logic       div_step;
		logic       q_store;
		logic       store;
		target_t    target;
		logic       mul_en;
		mul_sel_t   mul_sel;
		logic       comb;
		logic       set_err;
		logic [1:0] err_code;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic den_zero;
		logic gcd_done;
		logic div_done;
		logic div_by_zero;
		logic ovf;
	} stat_t;

endpackage

[hdl/rau_datapath.sv]
module rau_datapath #(
	parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rau_pkg::cmd_t       cmd,
	output rau_pkg::stat_t      st,
	input  logic [1:0]          opcode,
	input  logic signed [31:0]  left_numerator,
	input  logic signed [31:0]  left_denominator,
	input  logic signed [31:0]  right_numerator,
	input  logic signed [31:0]  right_denominator,
	output logic signed [31:0]  result_numerator,
	output logic [30:0]         result_denominator,
	output logic [1:0]          status
);

	localparam int W  = DATA_WIDTH;
	localparam int MW = 2 * W + 1;
	localparam int CW = $clog2(MW + 1);

	logic [1:0]    op_q;
	logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic          a_neg_q, b_neg_q, r_neg_q;
	logic [MW-1:0] fn_q, fd_q, x_q, y_q, dq_q, rem_q, dv_q, rn_q, rd_q;
	logic [CW-1:0] k_q, cnt_q;
	logic [2*W-1:0] p1_q, p2_q;
	logic [1:0]    err_q;

	function automatic logic [W-1:0] mag_of(input logic [31:0] v);
		logic [W-1:0] x;
		x = v[W-1:0];
		return x[W-1] ? (~x + 1'b1) : x;
	endfunction

	// Shared multiplier; operands chosen by the controller's step.
	logic [W-1:0]   mul_a, mul_b;
	logic [2*W-1:0] prod;
	always_comb begin
		case (cmd.mul_sel)
			rau_pkg::MUL_P1: begin
				mul_a = an_q;
				mul_b = (op_q == rau_pkg::OP_MUL) ? bn_q : bd_q;
			end
			rau_pkg::MUL_P2: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = (op_q == rau_pkg::OP_DIV) ? bn_q : bd_q;
			end
		endcase
	end
	assign prod = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

	// Sign-magnitude combine of the cross products.
	logic          s1, s2;
	logic [MW-1:0] comb_n;
	logic          comb_neg;
	always_comb begin
		s1 = a_neg_q;
		s2 = (op_q == rau_pkg::OP_SUB) ? !b_neg_q : b_neg_q;
		if (op_q == rau_pkg::OP_MUL || op_q == rau_pkg::OP_DIV) begin
			comb_n   = {1'b0, p1_q};
			comb_neg = a_neg_q ^ b_neg_q;
		end else if (s1 == s2) begin
			comb_n   = {1'b0, p1_q} + {1'b0, p2_q};
			comb_neg = s1;
		end else if (p1_q >= p2_q) begin
			comb_n   = {1'b0, p1_q - p2_q};
			comb_neg = s1;
		end else begin
			comb_n   = {1'b0, p2_q - p1_q};
			comb_neg = s2;
		end
	end

	logic [MW-1:0] sel_n, sel_d;
	always_comb begin
		case (cmd.target)
			rau_pkg::TGT_A: begin
				sel_n = MW'(an_q);
				sel_d = MW'(ad_q);
			end
			rau_pkg::TGT_B: begin
				sel_n = MW'(bn_q);
				sel_d = MW'(bd_q);
			end
			default: begin
				sel_n = rn_q;
				sel_d = rd_q;
			end
		endcase
	end

	logic [MW:0]   trial, diff;
	logic          ge;
	assign trial = {rem_q, dq_q[MW-1]};
	assign diff  = trial - {1'b0, dv_q};
	assign ge    = trial >= {1'b0, dv_q};

	logic [MW-1:0] top, lim, nsel;
	logic [W-1:0]  res_n;
	assign top   = MW'(1) << (W - 1);
	assign lim   = r_neg_q ? top : top - 1'b1;
	assign nsel  = r_neg_q ? (~rn_q + 1'b1) : rn_q;
	assign res_n = nsel[W-1:0];

	assign st.den_zero    = (ad_q == '0) || (bd_q == '0);
	assign st.gcd_done    = (x_q == '0);
	assign st.div_done    = (cnt_q == CW'(MW));
	assign st.div_by_zero = (op_q == rau_pkg::OP_DIV) && (bn_q == '0);
	assign st.ovf         = (rn_q > lim) || (rd_q > top - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= rau_pkg::ST_OK;
			cnt_q <= '0;
		end else begin
			if (cmd.load)
				err_q <= rau_pkg::ST_OK;
			else if (cmd.set_err)
				err_q <= cmd.err_code;
			if (cmd.div_start)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			an_q    <= mag_of(left_numerator);
			ad_q    <= mag_of(left_denominator);
			bn_q    <= mag_of(right_numerator);
			bd_q    <= mag_of(right_denominator);
			a_neg_q <= left_numerator[W-1] ^ left_denominator[W-1];
			b_neg_q <= right_numerator[W-1] ^ right_denominator[W-1];
		end
		if (cmd.fset) begin
			fn_q <= sel_n;
			fd_q <= sel_d;
			x_q  <= sel_n;
			y_q  <= sel_d;
			k_q  <= '0;
		end
		// Binary GCD step; the denominator is never zero here.
		if (cmd.gcd_step && x_q != '0) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= (x_q - y_q) >> 1;
			end else begin
				y_q <= (y_q - x_q) >> 1;
			end
		end
		// A start issued together with the numerator's store begins the
		// division of the denominator.
		if (cmd.div_start) begin
			dq_q  <= (cmd.div_den || cmd.q_store) ? fd_q : fn_q;
			rem_q <= '0;
			dv_q  <= y_q << k_q;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[MW-1:0] : trial[MW-1:0];
			dq_q  <= {dq_q[MW-2:0], ge};
		end
		if (cmd.q_store) begin
			if (cmd.div_den)
				fd_q <= dq_q;
			else
				fn_q <= dq_q;
		end
		if (cmd.store) begin
			case (cmd.target)
				rau_pkg::TGT_A: begin
					an_q    <= fn_q[W-1:0];
					ad_q    <= fd_q[W-1:0];
					a_neg_q <= a_neg_q && (fn_q != '0);
				end
				rau_pkg::TGT_B: begin
					bn_q    <= fn_q[W-1:0];
					bd_q    <= fd_q[W-1:0];
					b_neg_q <= b_neg_q && (fn_q != '0);
				end
				default: begin
					rn_q    <= fn_q;
					rd_q    <= fd_q;
					r_neg_q <= r_neg_q && (fn_q != '0);
				end
			endcase
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				rau_pkg::MUL_P1: p1_q <= prod;
				rau_pkg::MUL_P2: p2_q <= prod;
				default:         rd_q <= {1'b0, prod};
			endcase
		end
		if (cmd.comb) begin
			rn_q    <= comb_n;
			r_neg_q <= comb_neg;
		end
		if (cmd.out_load) begin
			status <= err_q;
			if (err_q != rau_pkg::ST_OK) begin
				result_numerator   <= '0;
				result_denominator <= 31'd1;
			end else begin
				result_numerator   <= 32'($signed(res_n));
				result_denominator <= 31'(rd_q[W-2:0]);
			end
		end
	end

endmodule

[hdl/rau_controller.sv]
module rau_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  rau_pkg::stat_t st,
	output rau_pkg::cmd_t  cmd
);

	rau_pkg::state_t  state_q, state_d;
	rau_pkg::target_t tgt_q, tgt_d;
	logic             out_valid_q;

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != rau_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rau_pkg::S_IDLE;
			tgt_q       <= rau_pkg::TGT_A;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tgt_q   <= tgt_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d    = state_q;
		tgt_d      = tgt_q;
		cmd        = '0;
		cmd.target = tgt_q;
		cmd.mul_sel = rau_pkg::MUL_P1;
		case (state_q)
			rau_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = rau_pkg::S_CHECK;
				end
			end
			rau_pkg::S_CHECK: begin
				if (st.den_zero) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = rau_pkg::ST_ZERO_DEN;
					state_d      = rau_pkg::S_DONE;
				end else begin
					tgt_d   = rau_pkg::TGT_A;
					state_d = rau_pkg::S_FSET;
				end
			end
			rau_pkg::S_FSET: begin
				cmd.fset = 1'b1;
				state_d  = rau_pkg::S_GCD;
			end
			rau_pkg::S_GCD: begin
				if (st.gcd_done) begin
					cmd.div_start = 1'b1;
					state_d       = rau_pkg::S_DIVN;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			rau_pkg::S_DIVN: begin
				if (st.div_done) begin
					cmd.q_store   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_den   = 1'b0;
					state_d       = rau_pkg::S_DIVD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			rau_pkg::S_DIVD: begin
				cmd.div_den = 1'b1;
				if (st.div_done) begin
					cmd.q_store = 1'b1;
					state_d     = rau_pkg::S_STORE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			rau_pkg::S_STORE: begin
				cmd.store = 1'b1;
				case (tgt_q)
					rau_pkg::TGT_A: begin
						tgt_d   = rau_pkg::TGT_B;
						state_d = rau_pkg::S_FSET;
					end
					rau_pkg::TGT_B: state_d = rau_pkg::S_OPSEL;
					default:        state_d = rau_pkg::S_FIN;
				endcase
			end
			rau_pkg::S_OPSEL: begin
				if (st.div_by_zero) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = rau_pkg::ST_DIV_ZERO;
					state_d      = rau_pkg::S_DONE;
				end else begin
					state_d = rau_pkg::S_MUL1;
				end
			end
			rau_pkg::S_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rau_pkg::MUL_P1;
				state_d     = rau_pkg::S_MUL2;
			end
			rau_pkg::S_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rau_pkg::MUL_P2;
				state_d     = rau_pkg::S_MUL3;
			end
			rau_pkg::S_MUL3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rau_pkg::MUL_DEN;
				state_d     = rau_pkg::S_COMB;
			end
			rau_pkg::S_COMB: begin
				cmd.comb = 1'b1;
				tgt_d    = rau_pkg::TGT_R;
				state_d  = rau_pkg::S_FSET;
			end
			rau_pkg::S_FIN: begin
				if (st.ovf) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = rau_pkg::ST_OVERFLOW;
				end
				state_d = rau_pkg::S_DONE;
			end
			rau_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = rau_pkg::S_IDLE;
				end
			end
			default: state_d = rau_pkg::S_IDLE;
		endcase
	end

endmodule

[hdl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: exact add, subtract, multiply and divide of two
// fractions, with both operands and the result reduced to lowest terms.
// The input channel (in_valid, in_stall) moves one transaction holding the
// opcode and two signed numerator/denominator pairs. A transaction is taken
// when in_valid is high and in_stall is low; in_stall is high while the
// block works on an item, so one item is in flight at a time.
// The output channel (out_valid, out_stall) moves one transaction per input:
// the reduced numerator carrying the sign, a positive denominator and a
// status code. An error status forces the result to 0/1.
// Latency is data dependent. Each of the three reductions (left operand,
// right operand, result) runs a binary GCD at one step per cycle, then
// two restoring divisions through one shared divider. The cross products
// and the denominator product come from one shared multiplier. An item
// with a zero denominator skips the reductions and goes straight to the
// result. The next item can be taken in the cycle after the result is posted.
// If the receiver stalls, the result register holds its transaction and a
// new input is still accepted; the block waits only when a second result
// is ready before the first has left. Reset clears the controller and the
// output valid; no result is pending after reset.
module rational_arithmetic_unit #(
	parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] left_numerator,
	input  logic signed [31:0] left_denominator,
	input  logic signed [31:0] right_numerator,
	input  logic signed [31:0] right_denominator,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_numerator,
	output logic [30:0]        result_denominator,
	output logic [1:0]         status
);

	// Commands from the sequencer and status flags back from the datapath.
	rau_pkg::cmd_t  cmd;
	rau_pkg::stat_t st;

	rau_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	rau_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.st                 (st),
		.opcode             (opcode),
		.left_numerator     (left_numerator),
		.left_denominator   (left_denominator),
		.right_numerator    (right_numerator),
		.right_denominator  (right_denominator),
		.result_numerator   (result_numerator),
		.result_denominator (result_denominator),
		.status             (status)
	);

endmodule

[hdl/rau_checker.sv]
`include "rational_arithmetic_unit_defines.svh"

module rau_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] result_numerator,
	input logic [30:0]        result_denominator,
	input logic [1:0]         status
);

	`RAU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(result_numerator) && $stable(result_denominator))
	`RAU_ASSERT_SAME(a_err_result, out_valid && status != rau_pkg::ST_OK, result_numerator == 32'sd0 && result_denominator == 31'd1)
	`RAU_ASSERT_SAME(a_den_nonzero, out_valid, result_denominator != 31'd0)
	`RAU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	// Clock, reset and the two channels of the unit under test.
	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         opcode;
	logic signed [31:0] left_numerator;
	logic signed [31:0] left_denominator;
	logic signed [31:0] right_numerator;
	logic signed [31:0] right_denominator;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] result_numerator;
	logic [30:0]        result_denominator;
	logic [1:0]         status;

	// A fraction held as sign and exact 64-bit magnitudes, the way the
	// unit keeps its double-width intermediates.
	typedef struct {
		bit        neg;
		bit [63:0] num;
		bit [63:0] den;
	} fraction_t;

	// One predicted output transaction.
	typedef struct {
		logic [31:0] num;
		logic [30:0] den;
		logic [1:0]  st;
	} quotient_t;

	quotient_t pending_results[$];

	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned error_count;
	int unsigned op_count[4];
	int unsigned status_count[4];

	// Traffic shaping knobs, changed by the test tasks.
	bit          quiet_mode;
	int unsigned hold_left;
	int unsigned stall_left;

	rational_arithmetic_unit u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.opcode             (opcode),
		.left_numerator     (left_numerator),
		.left_denominator   (left_denominator),
		.right_numerator    (right_numerator),
		.right_denominator  (right_denominator),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.result_numerator   (result_numerator),
		.result_denominator (result_denominator),
		.status             (status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction of the unit, worked at full 32-bit operand width.
	// ------------------------------------------------------------------

	function automatic bit [63:0] euclid_gcd(input bit [63:0] a, input bit [63:0] b);
		bit [63:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// Bring a fraction to lowest terms; a zero numerator becomes +0/1.
	function automatic fraction_t lowest_terms(input fraction_t f);
		bit [63:0] g;
		if (f.num == 0) begin
			f.neg = 1'b0;
			f.den = 64'd1;
		end else begin
			g = euclid_gcd(f.num, f.den);
			if (g > 1) begin
				f.num = f.num / g;
				f.den = f.den / g;
			end
		end
		return f;
	endfunction

	function automatic bit [63:0] magnitude_of(input logic [31:0] raw);
		return raw[31] ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
	endfunction

	// Normalizes one operand; the returned flag is low for a zero denominator.
	function automatic bit normalize_operand(input logic [31:0] n_raw,
			input logic [31:0] d_raw, output fraction_t f);
		f.neg = n_raw[31] ^ d_raw[31];
		f.num = magnitude_of(n_raw);
		f.den = magnitude_of(d_raw);
		if (f.den == 0)
			return 1'b0;
		f = lowest_terms(f);
		return 1'b1;
	endfunction

	function automatic quotient_t predict_fraction(input logic [1:0] op,
			input logic [31:0] ln, input logic [31:0] ld,
			input logic [31:0] rn, input logic [31:0] rd);
		fraction_t a, b, r;
		bit        ok_a, ok_b, s1, s2;
		bit [63:0] p1, p2, lim, n;
		quotient_t q;
		ok_a = normalize_operand(ln, ld, a);
		ok_b = normalize_operand(rn, rd, b);
		r.neg = 1'b0;
		r.num = 0;
		r.den = 1;
		q.st = rau_pkg::ST_OK;
		if (!ok_a || !ok_b) begin
			q.st = rau_pkg::ST_ZERO_DEN;
		end else if (op == rau_pkg::OP_DIV && b.num == 0) begin
			q.st = rau_pkg::ST_DIV_ZERO;
		end else begin
			case (op)
				rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
					p1 = a.num * b.den;
					p2 = b.num * a.den;
					s1 = a.neg;
					s2 = (op == rau_pkg::OP_SUB) ? !b.neg : b.neg;
					if (s1 == s2) begin
						r.num = p1 + p2;
						r.neg = s1;
					end else if (p1 >= p2) begin
						r.num = p1 - p2;
						r.neg = s1;
					end else begin
						r.num = p2 - p1;
						r.neg = s2;
					end
					r.den = a.den * b.den;
				end
				rau_pkg::OP_MUL: begin
					r.num = a.num * b.num;
					r.den = a.den * b.den;
					r.neg = a.neg ^ b.neg;
				end
				default: begin
					r.num = a.num * b.den;
					r.den = a.den * b.num;
					r.neg = a.neg ^ b.neg;
				end
			endcase
			r = lowest_terms(r);
			lim = r.neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
			if (r.num > lim || r.den > 64'h7FFF_FFFF)
				q.st = rau_pkg::ST_OVERFLOW;
		end
		if (q.st != rau_pkg::ST_OK) begin
			q.num = 32'd0;
			q.den = 31'd1;
		end else begin
			n = r.neg ? (64'd0 - r.num) : r.num;
			q.num = n[31:0];
			q.den = r.den[30:0];
		end
		return q;
	endfunction

	// ------------------------------------------------------------------
	// Input side: one shared task offers a transaction and waits for it
	// to be taken, then leaves a random gap unless quiet mode is on.
	// ------------------------------------------------------------------

	task automatic send_fraction_pair(input logic [1:0] op,
			input logic [31:0] ln, input logic [31:0] ld,
			input logic [31:0] rn, input logic [31:0] rd);
		int unsigned gap;
		int unsigned pick;
		in_valid          <= 1'b1;
		opcode            <= op;
		left_numerator    <= ln;
		left_denominator  <= ld;
		right_numerator   <= rn;
		right_denominator <= rd;
		// The edge at which in_stall was seen low is the acceptance edge.
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_fraction(op, ln, ld, rn, rd));
		items_sent++;
		op_count[op]++;
		gap = 0;
		if (!quiet_mode) begin
			pick = $urandom_range(0, 99);
			if (pick >= 94)
				gap = $urandom_range(20, 90);
			else if (pick >= 65)
				gap = $urandom_range(1, 4);
		end
		// A zero gap keeps valid high, so the next call only updates payload.
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Pauses the sender until every predicted result has arrived.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Output side: random stalls, mostly short bursts with a few long ones,
	// plus a long hold-off counted here when a test asks for it.
	// ------------------------------------------------------------------

	initial begin
		int unsigned pick;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (!quiet_mode) begin
					pick = $urandom_range(0, 99);
					if (pick < 10)
						stall_left = $urandom_range(1, 3);
					else if (pick < 12)
						stall_left = $urandom_range(20, 120);
				end
			end
		end
	end

	// Result checker: every taken output transaction is compared with the
	// oldest prediction, field by field.
	always @(posedge clk) begin
		quotient_t exp_q;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result %0d/%0d status %0d", $time,
					result_numerator, result_denominator, status);
			end else begin
				exp_q = pending_results.pop_front();
				status_count[exp_q.st]++;
				if (result_numerator !== exp_q.num) begin
					error_count++;
					$display("%0t: numerator expected %0d actual %0d", $time,
						$signed(exp_q.num), result_numerator);
				end
				if (result_denominator !== exp_q.den) begin
					error_count++;
					$display("%0t: denominator expected %0d actual %0d", $time,
						exp_q.den, result_denominator);
				end
				if (status !== exp_q.st) begin
					error_count++;
					$display("%0t: status expected %0d actual %0d", $time,
						exp_q.st, status);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Operand generation for the random tests.
	// ------------------------------------------------------------------

	localparam logic [31:0] MOST_NEG = 32'h8000_0000;
	localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

	// Mostly small values so that reductions and results stay in range,
	// with full-width words and the edges of the range mixed in.
	function automatic logic [31:0] pick_word(input bit allow_zero);
		int unsigned kind;
		logic [31:0] w;
		kind = $urandom_range(0, 99);
		if (kind < 55)
			w = $urandom_range(1, 60) * ($urandom_range(0, 1) ? 1 : -1);
		else if (kind < 70)
			w = $urandom_range(1, 40000) * ($urandom_range(0, 1) ? 1 : -1);
		else if (kind < 88)
			w = $urandom;
		else begin
			case ($urandom_range(0, 4))
				0: w = MOST_NEG;
				1: w = MOST_POS;
				2: w = 32'hFFFF_FFFF;
				3: w = 32'd1;
				default: w = MOST_NEG + 1;
			endcase
		end
		if (allow_zero && $urandom_range(0, 19) == 0)
			w = 32'd0;
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Each operation on plain values, then the special cases: zero operands,
	// zero denominators and their precedence, division by a zero fraction,
	// overflow of numerator and denominator, and the most negative word.
	task automatic test_directed_cases();
		send_fraction_pair(rau_pkg::OP_ADD, 1, 2, 1, 3);
		send_fraction_pair(rau_pkg::OP_SUB, 1, 2, 3, 4);
		send_fraction_pair(rau_pkg::OP_MUL, -6, 4, 10, -9);
		send_fraction_pair(rau_pkg::OP_DIV, 3, -7, -9, 14);
		send_fraction_pair(rau_pkg::OP_ADD, 0, -5, 0, 7);
		send_fraction_pair(rau_pkg::OP_MUL, 0, 3, -4, 9);
		send_fraction_pair(rau_pkg::OP_ADD, 1, 0, 2, 3);
		send_fraction_pair(rau_pkg::OP_SUB, 2, 3, 1, 0);
		// Zero denominator wins over division by zero.
		send_fraction_pair(rau_pkg::OP_DIV, 5, 0, 0, 1);
		send_fraction_pair(rau_pkg::OP_DIV, 5, 3, 0, -8);
		send_fraction_pair(rau_pkg::OP_MUL, MOST_POS, 1, MOST_POS, 1);
		send_fraction_pair(rau_pkg::OP_MUL, 1, MOST_POS, 1, 2);
		send_fraction_pair(rau_pkg::OP_MUL, MOST_NEG, 1, 1, 1);
		send_fraction_pair(rau_pkg::OP_MUL, MOST_NEG, 32'hFFFF_FFFF, 1, 1);
		send_fraction_pair(rau_pkg::OP_DIV, MOST_NEG, 32'hFFFF_FFFF, 2, 1);
		send_fraction_pair(rau_pkg::OP_ADD, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS);
		send_fraction_pair(rau_pkg::OP_SUB, MOST_NEG, 1, 1, 1);
		send_fraction_pair(rau_pkg::OP_ADD, MOST_POS, 1, MOST_POS, 1);
		send_fraction_pair(rau_pkg::OP_DIV, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS);
		send_fraction_pair(rau_pkg::OP_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1);
		send_fraction_pair(rau_pkg::OP_DIV, 1, MOST_NEG, MOST_NEG, 1);
		wait_for_drain();
	endtask

	// Random operations and operands with random gaps and stalls.
	task automatic test_random_traffic(input int unsigned count);
		repeat (count) begin
			send_fraction_pair(2'($urandom_range(0, 3)), pick_word(1'b1),
				pick_word(1'b1), pick_word(1'b1), pick_word(1'b1));
		end
		wait_for_drain();
	endtask

	// The receiver holds off for a long time while items keep coming back
	// to back, so the result register fills and the input side stalls.
	task automatic test_output_backpressure();
		quiet_mode = 1'b1;
		hold_left  = 5000;
		repeat (6) begin
			send_fraction_pair(2'($urandom_range(0, 3)), pick_word(1'b0),
				pick_word(1'b0), pick_word(1'b0), pick_word(1'b0));
		end
		wait_for_drain();
		quiet_mode = 1'b0;
	endtask

	// A stretch with no idling on either side.
	task automatic test_full_rate();
		quiet_mode = 1'b1;
		repeat (20) begin
			send_fraction_pair(2'($urandom_range(0, 3)), pick_word(1'b1),
				pick_word(1'b1), pick_word(1'b1), pick_word(1'b1));
		end
		wait_for_drain();
		quiet_mode = 1'b0;
	endtask

	initial begin
		int unsigned settle;
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		opcode            = rau_pkg::OP_ADD;
		left_numerator    = '0;
		left_denominator  = '0;
		right_numerator   = '0;
		right_denominator = '0;
		quiet_mode        = 1'b0;
		hold_left         = 0;
		stall_left        = 0;
		items_sent        = 0;
		results_seen      = 0;
		error_count       = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(120);
		test_output_backpressure();
		test_full_rate();
		test_random_traffic(120);

		// Let the unit sit idle for a while to catch any stray result.
		settle = 0;
		while (settle < 1000) begin
			@(posedge clk);
			settle++;
		end
		if (pending_results.size() != 0) begin
			error_count++;
			$display("%0t: %0d predicted results never arrived", $time,
				pending_results.size());
		end

		$display("Covered %0d transactions in, %0d out: add %0d, sub %0d, mul %0d, div %0d.",
			items_sent, results_seen, op_count[rau_pkg::OP_ADD],
			op_count[rau_pkg::OP_SUB], op_count[rau_pkg::OP_MUL],
			op_count[rau_pkg::OP_DIV]);
		$display("Status mix: ok %0d, zero den %0d, div by zero %0d, overflow %0d.",
			status_count[rau_pkg::ST_OK], status_count[rau_pkg::ST_ZERO_DEN],
			status_count[rau_pkg::ST_DIV_ZERO], status_count[rau_pkg::ST_OVERFLOW]);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run of about 300 items.
	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
